// ===== hw/rtl/mpoc_pkg.sv =====
package mpoc_pkg;

    localparam int NUM_PATTERNS    = 4;
    localparam int MAX_PATTERN_LEN = 8;
    localparam int COUNT_WIDTH     = 16;

    localparam int PAT_SLOTS  = 4;
    localparam int OUT_W      = 16;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_FLD_W  = 4;
    localparam int LEN_REG_W  = PAT_SLOTS * LEN_FLD_W;
    localparam int PAT_W      = 8 * MAX_PATTERN_LEN;
    localparam int HIST_DEPTH = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1;
    localparam int SEEN_W     = $clog2(MAX_PATTERN_LEN + 1);
    localparam int BLK_W      = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CASE      = 3'd5;

    // one classified byte, front to back
    typedef struct packed {
        logic                                last;
        logic [NUM_PATTERNS-1:0]             active;
        logic [NUM_PATTERNS-1:0]             hit;
        logic [NUM_PATTERNS-1:0][BLK_W-1:0]  reload;
    } q_entry_t;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic cs);
        logic [7:0] r;
        r = c;
        if (!cs && (c inside {[8'h41:8'h5A]}))
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/mpoc_front.sv =====
module mpoc_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [mpoc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mpoc_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  push,
    input  logic [7:0]                            text_byte,
    input  logic                                  last_byte,
    output mpoc_pkg::q_entry_t                    entry
);

    localparam int NP  = mpoc_pkg::NUM_PATTERNS;
    localparam int ML  = mpoc_pkg::MAX_PATTERN_LEN;
    localparam int LFW = mpoc_pkg::LEN_FLD_W;

    logic [mpoc_pkg::PAT_W-1:0]     pattern_reg [NP];
    logic [mpoc_pkg::LEN_REG_W-1:0] lengths_reg;
    logic                           case_reg;
    logic [7:0]                     hist_reg [mpoc_pkg::HIST_DEPTH];
    logic [mpoc_pkg::SEEN_W-1:0]    seen_reg;
    logic [mpoc_pkg::SEEN_W-1:0]    seen_next;

    logic [7:0]     win [ML];
    logic [7:0]     fwin [ML];
    logic [LFW-1:0] len [NP];

    // configuration registers
    for (genvar p = 0; p < NP; p++)
    begin : g_pat
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pattern_reg[p] <= '0;
            end
            else if (cfg_valid &&
                     (cfg_index == mpoc_pkg::CFG_PATTERN_A + mpoc_pkg::CFG_IDX_W'(p)))
            begin
                pattern_reg[p] <= cfg_data[mpoc_pkg::PAT_W-1:0];
            end
        end

        always_comb
        begin
            len[p] = lengths_reg[LFW*p +: LFW];
            if (len[p] > LFW'(ML))
            begin
                len[p] = LFW'(ML);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lengths_reg <= '0;
            case_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == mpoc_pkg::CFG_LENGTHS)
            begin
                lengths_reg <= cfg_data[mpoc_pkg::LEN_REG_W-1:0];
            end
            if (cfg_index == mpoc_pkg::CFG_CASE)
            begin
                case_reg <= cfg_data[0];
            end
        end
    end

    // byte history and per-text byte count
    assign seen_next = (seen_reg == mpoc_pkg::SEEN_W'(ML)) ? seen_reg : seen_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            for (int i = 0; i < mpoc_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            if (last_byte)
            begin
                seen_reg <= '0;
                for (int i = 0; i < mpoc_pkg::HIST_DEPTH; i++)
                begin
                    hist_reg[i] <= '0;
                end
            end
            else
            begin
                seen_reg    <= seen_next;
                hist_reg[0] <= text_byte;
                for (int i = 1; i < mpoc_pkg::HIST_DEPTH; i++)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
            end
        end
    end

    // window: entry 0 is the incoming byte, entry j the byte j places back
    always_comb
    begin
        win[0] = text_byte;
        for (int j = 1; j < ML; j++)
        begin
            win[j] = hist_reg[j-1];
        end
        for (int j = 0; j < ML; j++)
        begin
            fwin[j] = mpoc_pkg::fold(win[j], case_reg);
        end
    end

    // parallel compare of every pattern at every candidate length
    always_comb
    begin
        logic       all_eq;
        logic [7:0] pb;
        entry.last = last_byte;
        for (int p = 0; p < NP; p++)
        begin
            entry.active[p] = (len[p] != '0);
            entry.reload[p] = mpoc_pkg::BLK_W'(len[p] - 1'b1);
            entry.hit[p]    = 1'b0;
            for (int l = 1; l <= ML; l++)
            begin
                all_eq = 1'b1;
                for (int k = 0; k < l; k++)
                begin
                    pb     = mpoc_pkg::fold(pattern_reg[p][8*k +: 8], case_reg);
                    all_eq = all_eq & (fwin[l-1-k] == pb);
                end
                if (len[p] == LFW'(l))
                begin
                    entry.hit[p] = all_eq;
                end
            end
            if (LFW'(seen_next) < len[p])
            begin
                entry.hit[p] = 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/mpoc_queue.sv =====
module mpoc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mpoc_pkg::q_entry_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output mpoc_pkg::q_entry_t head
);

    localparam int D = mpoc_pkg::QDEPTH;
    localparam int A = mpoc_pkg::QAW;

    mpoc_pkg::q_entry_t slot_reg [D];
    logic [A-1:0]       wr_ptr_reg;
    logic [A-1:0]       rd_ptr_reg;
    logic [A:0]         count_reg;

    assign full       = (count_reg == (A+1)'(D));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (A+1)'(D))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> !pop)
        else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/mpoc_back.sv =====
module mpoc_back (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           head_valid,
    input  mpoc_pkg::q_entry_t                             head,
    output logic                                           pop,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output logic [mpoc_pkg::PAT_SLOTS*mpoc_pkg::OUT_W-1:0] out_data
);

    localparam int NP = mpoc_pkg::NUM_PATTERNS;
    localparam int CW = mpoc_pkg::COUNT_WIDTH;
    localparam int OW = mpoc_pkg::OUT_W;

    logic [mpoc_pkg::BLK_W-1:0] blocked_reg [NP];
    logic [mpoc_pkg::BLK_W-1:0] blocked_next [NP];
    logic [CW-1:0]              count_reg [NP];
    logic [CW-1:0]              count_next [NP];
    logic                       out_valid_reg;
    logic [mpoc_pkg::PAT_SLOTS*OW-1:0] out_data_reg;
    logic [mpoc_pkg::PAT_SLOTS*OW-1:0] out_data_next;
    logic                       pop_last;

    // a last entry needs the output register free
    assign pop       = head_valid && (!head.last || !out_valid_reg || out_ready);
    assign pop_last  = pop && head.last;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        logic [31:0] wide;
        out_data_next = '0;
        for (int p = 0; p < NP; p++)
        begin
            blocked_next[p] = blocked_reg[p];
            count_next[p]   = count_reg[p];
            if (head.active[p])
            begin
                if (blocked_reg[p] != '0)
                begin
                    blocked_next[p] = blocked_reg[p] - 1'b1;
                end
                else if (head.hit[p])
                begin
                    if (count_reg[p] != '1)
                    begin
                        count_next[p] = count_reg[p] + 1'b1;
                    end
                    blocked_next[p] = head.reload[p];
                end
            end
            wide = 32'(count_next[p]);
            out_data_next[OW*p +: OW] = wide[OW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NP; p++)
            begin
                blocked_reg[p] <= '0;
                count_reg[p]   <= '0;
            end
        end
        else if (pop)
        begin
            for (int p = 0; p < NP; p++)
            begin
                if (head.last)
                begin
                    blocked_reg[p] <= '0;
                    count_reg[p]   <= '0;
                end
                else
                begin
                    blocked_reg[p] <= blocked_next[p];
                    count_reg[p]   <= count_next[p];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_last)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop_last |=> (count_reg[0] == '0) && (blocked_reg[0] == '0))
        else $error("state not cleared after last byte");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pop_last))
        else $error("result raised without a last byte");
`endif

endmodule

// ===== hw/rtl/multi_pattern_occurrence_counter_unit.sv =====
// Multi-pattern occurrence counter.
// s_* : text bytes, one per request; s_tdata = text_byte, s_tlast = last byte of a text.
// m_* : one request per text, carrying four 16-bit counts of non-overlapping,
//       left-to-right greedy matches of patterns a..d (saturating).
// cfg_*: register writes (0..3 patterns, 4 lengths, 5 case mode); always ready; the user
//       writes them only between texts or while no byte is in flight (not enforced).
// Flow: the front stage folds case (unless case mode is set) and compares all
// patterns against an 8-byte window in the accept cycle, then pushes a match
// vector into a 4-entry queue; the back stage applies the overlap block and counts.
// Throughput: one byte per cycle sustained while the queue has room. The back
// stage only stalls on a last byte while the previous result is still unread.
// Result path: the last byte is written into the queue when accepted, and
// m_tvalid rises when the back stage pops it into the output register.
// Reset: config registers, history and counts zero, queue empty, m_tvalid low.
// Receiver stall: the result holds in the output register; bytes keep
// flowing until a second last byte reaches the back stage, then the queue
// fills and s_tready drops.
module multi_pattern_occurrence_counter_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // config write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mpoc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mpoc_pkg::CFG_W-1:0]             cfg_data,
    // text input
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [7:0]                             s_tdata,   // text_byte[7:0]
    input  logic                                   s_tlast,   // last_byte
    // count output
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // count_a[15:0], count_b[31:16], count_c[47:32], count_d[63:48]
    output logic [mpoc_pkg::PAT_SLOTS*mpoc_pkg::OUT_W-1:0] m_tdata
);

    logic               push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    mpoc_pkg::q_entry_t front_entry;
    mpoc_pkg::q_entry_t q_head;

    // registers are plain flops, so a write can always land
    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign push      = s_tvalid && s_tready;

    mpoc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .text_byte (s_tdata),
        .last_byte (s_tlast),
        .entry     (front_entry)
    );

    mpoc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    mpoc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

endmodule
